@@ sv/jsu_pkg.sv @@
// shared types, codes and helper function of the json string unescaper
package jsu_pkg;

    // decode phase codes
    localparam logic [1:0] PH_NORMAL  = 2'd0;
    localparam logic [1:0] PH_ESCAPE  = 2'd1;
    localparam logic [1:0] PH_HEX     = 2'd2;
    localparam logic [1:0] PH_STOPPED = 2'd3;

    // byte codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;

    // replacement character U+FFFD in utf-8
    localparam logic [7:0] REPL_0 = 8'hEF;
    localparam logic [7:0] REPL_1 = 8'hBF;
    localparam logic [7:0] REPL_2 = 8'hBD;

    // utf-8 limits and lead/continuation marks
    localparam logic [15:0] UTF8_ONE_MAX = 16'h0080;
    localparam logic [15:0] UTF8_TWO_MAX = 16'h0800;
    localparam logic [7:0]  UTF8_LEAD2   = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3   = 8'hE0;
    localparam logic [7:0]  UTF8_CONT    = 8'h80;

    localparam int unsigned MAX_OUT = 3;

    typedef struct packed {
        logic [1:0]  phase;
        logic        first;
        logic        quoted;
        logic [15:0] accum;
        logic [1:0]  seen;
        logic        all_valid;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase: PH_NORMAL, first: 1'b1, quoted: 1'b0,
        accum: 16'h0000, seen: 2'd0, all_valid: 1'b1
    };

    // all result items caused by one input item
    typedef struct packed {
        logic [MAX_OUT-1:0][7:0] bytes;
        logic [1:0]              count;     // 1..3 items
        logic                    has_data;  // 0: single empty end item
        logic                    str_end;
    } t_bundle;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } t_hex;

    function automatic t_hex hex_value(input logic [7:0] b);
        t_hex h;
        h.valid = 1'b1;
        h.value = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            h.value = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            h.value = 4'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            h.value = 4'(b - 8'h37);
        end else begin
            h.valid = 1'b0;
        end
        return h;
    endfunction

endpackage

@@ sv/json_string_unescaper.sv @@
// top level of the json string unescaper: input stage, decode state, output buffer
//
//  channel  dir  tdata        tlast       tuser
//  s_axis   in   in_byte[7:0] in_last     -
//  m_axis   out  out_byte     string_end  [0] out_valid, [1] run_last
//
// one raw byte is taken per cycle into the input register while s_axis_tready is high,
// decoded combinationally and loaded into the result buffer, which sends 1 to 3 items
// an item that expands to n bytes holds the input side until the single output port
// of the result buffer has sent all n of them; bytes that give nothing pass on
// without touching the buffer
// reset (synchronous, active low) empties both stages and returns the decoder
// to the start of a string; a stall on m_axis backs up into s_axis_tready
module json_string_unescaper (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast,
    output logic [1:0] m_axis_tuser    // [0] out_valid, [1] run_last
);

    // input register
    logic            r_in_valid;
    logic [7:0]      r_in_byte;
    logic            r_in_last;

    // decoder state across bytes of one string
    jsu_pkg::t_state r_state;
    jsu_pkg::t_state state_next;

    jsu_pkg::t_bundle bundle;
    logic             has_result;
    logic             can_load;
    logic             advance;   // input register item is consumed this cycle
    logic             in_fire;

    jsu_decode u_decode (
        .i_state      (r_state),
        .i_byte       (r_in_byte),
        .i_last       (r_in_last),
        .o_state_next (state_next),
        .o_bundle     (bundle),
        .o_has_result (has_result)
    );

    // an item with no result needs no room in the buffer
    assign advance       = r_in_valid && (!has_result || can_load);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= jsu_pkg::STATE_RESET;
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_state <= state_next;
            end
        end
        if (in_fire) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    jsu_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (advance && has_result),
        .i_bundle      (bundle),
        .o_can_load    (can_load),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // the end of a string always leaves the decoder at its start state
    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_last) |=> (r_state == jsu_pkg::STATE_RESET))
        else $error("decoder state not back to start after last byte");

    // the last byte always produces at least one item
    a_last_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in_last) |-> has_result)
        else $error("last byte gave no result item");

endmodule

@@ sv/jsu_decode.sv @@
// combinational decode of one raw byte into up to three output bytes
module jsu_decode (
    input  jsu_pkg::t_state  i_state,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    output jsu_pkg::t_state  o_state_next,
    output jsu_pkg::t_bundle o_bundle,
    output logic             o_has_result
);

    jsu_pkg::t_state ns;
    jsu_pkg::t_hex   hx;
    logic            take;
    logic [15:0]     acc_new;
    logic            allv_new;
    logic [jsu_pkg::MAX_OUT-1:0][7:0] bytes;
    logic [1:0]      cnt;

    always_comb begin
        ns       = i_state;
        bytes    = '0;
        cnt      = 2'd0;
        hx       = jsu_pkg::hex_value(i_byte);
        acc_new  = hx.valid ? {i_state.accum[11:0], hx.value} : i_state.accum;
        allv_new = i_state.all_valid & hx.valid;

        // opening quote is swallowed; in a quoted string the final byte too
        take = 1'b1;
        if (i_state.first) begin
            ns.first = 1'b0;
            if (i_byte == jsu_pkg::CH_QUOTE) begin
                ns.quoted = 1'b1;
                take      = 1'b0;
            end
        end else if (i_state.quoted && i_last) begin
            take = 1'b0;
        end

        if (take) begin
            unique case (i_state.phase)
                jsu_pkg::PH_NORMAL: begin
                    if (i_byte == jsu_pkg::CH_NUL) begin
                        ns.phase = jsu_pkg::PH_STOPPED;
                    end else if (i_byte == jsu_pkg::CH_BSLASH) begin
                        ns.phase = jsu_pkg::PH_ESCAPE;
                    end else if (i_byte >= jsu_pkg::CH_SPACE) begin
                        bytes[0] = i_byte;
                        cnt      = 2'd1;
                    end
                end
                jsu_pkg::PH_ESCAPE: begin
                    ns.phase = jsu_pkg::PH_NORMAL;
                    cnt      = 2'd1;
                    unique case (i_byte)
                        jsu_pkg::CH_NUL: begin
                            bytes[0] = jsu_pkg::CH_BSLASH;
                            ns.phase = jsu_pkg::PH_STOPPED;
                        end
                        jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH,
                        jsu_pkg::CH_SLASH: bytes[0] = i_byte;
                        jsu_pkg::CH_B:     bytes[0] = jsu_pkg::CH_BS;
                        jsu_pkg::CH_F:     bytes[0] = jsu_pkg::CH_FF;
                        jsu_pkg::CH_N:     bytes[0] = jsu_pkg::CH_LF;
                        jsu_pkg::CH_R:     bytes[0] = jsu_pkg::CH_CR;
                        jsu_pkg::CH_T:     bytes[0] = jsu_pkg::CH_TAB;
                        jsu_pkg::CH_U: begin
                            cnt          = 2'd0;
                            ns.phase     = jsu_pkg::PH_HEX;
                            ns.accum     = 16'h0000;
                            ns.seen      = 2'd0;
                            ns.all_valid = 1'b1;
                        end
                        default: begin
                            bytes = {jsu_pkg::REPL_2, jsu_pkg::REPL_1, jsu_pkg::REPL_0};
                            cnt   = 2'd3;
                        end
                    endcase
                end
                jsu_pkg::PH_HEX: begin
                    ns.accum     = acc_new;
                    ns.all_valid = allv_new;
                    if (i_state.seen == 2'd3) begin
                        ns.phase = jsu_pkg::PH_NORMAL;
                        ns.seen  = 2'd0;
                        if (!allv_new) begin
                            bytes = {jsu_pkg::REPL_2, jsu_pkg::REPL_1, jsu_pkg::REPL_0};
                            cnt   = 2'd3;
                        end else if (acc_new < jsu_pkg::UTF8_ONE_MAX) begin
                            bytes[0] = acc_new[7:0];
                            cnt      = 2'd1;
                        end else if (acc_new < jsu_pkg::UTF8_TWO_MAX) begin
                            bytes[0] = jsu_pkg::UTF8_LEAD2 | {3'b000, acc_new[10:6]};
                            bytes[1] = jsu_pkg::UTF8_CONT | {2'b00, acc_new[5:0]};
                            cnt      = 2'd2;
                        end else begin
                            bytes[0] = jsu_pkg::UTF8_LEAD3 | {4'b0000, acc_new[15:12]};
                            bytes[1] = jsu_pkg::UTF8_CONT | {2'b00, acc_new[11:6]};
                            bytes[2] = jsu_pkg::UTF8_CONT | {2'b00, acc_new[5:0]};
                            cnt      = 2'd3;
                        end
                    end else begin
                        ns.seen = i_state.seen + 2'd1;
                    end
                end
                default: ;  // stopped: ignore bytes
            endcase
        end

        // unfinished escape at the end; nothing was produced in that case
        if (i_last) begin
            if (ns.phase == jsu_pkg::PH_ESCAPE) begin
                bytes[0] = jsu_pkg::CH_BSLASH;
                cnt      = 2'd1;
            end else if (ns.phase == jsu_pkg::PH_HEX) begin
                bytes = {jsu_pkg::REPL_2, jsu_pkg::REPL_1, jsu_pkg::REPL_0};
                cnt   = 2'd3;
            end
            ns = jsu_pkg::STATE_RESET;
        end
    end

    assign o_state_next      = ns;
    assign o_has_result      = (cnt != 2'd0) || i_last;
    assign o_bundle.bytes    = bytes;
    assign o_bundle.count    = (cnt == 2'd0) ? 2'd1 : cnt;
    assign o_bundle.has_data = (cnt != 2'd0);
    assign o_bundle.str_end  = i_last;

endmodule

@@ sv/jsu_emit.sv @@
// result buffer that sends out the items of one decoded bundle one by one
module jsu_emit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  jsu_pkg::t_bundle i_bundle,
    output logic             o_can_load,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [7:0]       m_axis_tdata,
    output logic             m_axis_tlast,
    output logic [1:0]       m_axis_tuser
);

    jsu_pkg::t_bundle r_buf, n_buf;
    logic             r_valid, n_valid;
    logic [1:0]       r_idx, n_idx;
    logic             fire, fin;

    assign fire       = r_valid && m_axis_tready;
    assign fin        = (r_idx == r_buf.count - 2'd1);
    assign o_can_load = !r_valid || (fire && fin);

    always_comb begin
        n_buf   = r_buf;
        n_valid = r_valid;
        n_idx   = r_idx;
        if (fire) begin
            if (fin) begin
                n_valid = 1'b0;
            end else begin
                n_idx = r_idx + 2'd1;
            end
        end
        if (i_load) begin
            n_buf   = i_bundle;
            n_valid = 1'b1;
            n_idx   = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
        r_buf <= n_buf;
    end

    assign m_axis_tvalid   = r_valid;
    assign m_axis_tdata    = r_buf.has_data ? r_buf.bytes[r_idx] : 8'h00;
    assign m_axis_tlast    = r_buf.str_end && fin;
    assign m_axis_tuser[0] = r_buf.has_data;
    assign m_axis_tuser[1] = fin;

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_idx < r_buf.count))
        else $error("item index beyond bundle count");

    a_empty_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_buf.has_data) |-> (m_axis_tdata == 8'h00 && fin))
        else $error("empty end item is not a single zero item");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_can_load)
        else $error("bundle loaded over one still being sent");

endmodule
